// ===== rtl/core/scc_pkg.sv =====
// scc_pkg: shared constants, types and helpers for the seam cumulative cost block
// used by scc_line_buf, scc_cost_unit and seam_cumulative_cost_top; no dependencies
`default_nettype none

package scc_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 12;
  localparam int ENERGY_BITS = 16;
  localparam int COST_BITS   = 32;

  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [WIDTH_BITS-1:0]  width_t;
  typedef logic [ENERGY_BITS-1:0] energy_t;
  typedef logic [COST_BITS-1:0]   cost_t;

  // write request into the line buffer
  typedef struct packed {
    logic  en;
    col_t  addr;
    cost_t data;
  } lb_wr_t;

  // base-row mode and which previous-row neighbors take part in the minimum
  typedef struct packed {
    logic base_row;
    logic use_left;
    logic use_right;
  } cost_sel_t;

  // width register clamped to 1..MAX_WIDTH
  function automatic width_t eff_width(input width_t w);
    width_t r;
    r = w;
    if (w == '0) begin
      r = width_t'(1);
    end else if (w > width_t'(MAX_WIDTH)) begin
      r = width_t'(MAX_WIDTH);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/seam_cumulative_cost_top.sv =====
// seam_cumulative_cost_top: streaming cumulative seam cost, column control and output register
// uses scc_pkg, scc_line_buf and scc_cost_unit
//
//   channel  ports                                    direction
//   in       in_valid in_ready in_energy in_frame_start  sink, one item per pixel
//   out      out_valid out_ready out_cost out_row_end     source, one item per input item
//   cfg      cfg_wr_en cfg_wr_data                        write only, image width
//
// one item per cycle sustained while out_ready is high; an item's result shows in out_* the cycle after acceptance
// line buffer reads are issued ahead from the next column, so no read bubble
// reset clears column, left cost and out_valid, sets the base-row flag and width (2048); the line buffer is not cleared
// in_ready drops only while a result sits in the output register and out_ready is low
`default_nettype none

module seam_cumulative_cost_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scc_pkg::energy_t     in_energy,
  input  wire logic                 in_frame_start,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scc_pkg::cost_t            out_cost,
  output logic                      out_row_end,
  input  wire logic                 cfg_wr_en,
  input  wire scc_pkg::width_t      cfg_wr_data
);

  scc_pkg::col_t   col_r,   col_nxt;
  logic            base_r,  base_nxt;
  scc_pkg::cost_t  left_r,  left_nxt;
  scc_pkg::width_t width_r, width_nxt;
  logic            out_valid_r,   out_valid_nxt;
  scc_pkg::cost_t  out_cost_r;
  logic            out_row_end_r;

  logic               accept;
  scc_pkg::width_t    w;
  scc_pkg::width_t    w_la;
  scc_pkg::col_t      col_s;
  logic               base_s;
  scc_pkg::col_t      c;
  logic               row_base;
  scc_pkg::width_t    c_plus1;
  logic               last;
  scc_pkg::col_t      c_la;
  scc_pkg::col_t      rd_a_addr;
  scc_pkg::col_t      rd_b_addr;
  scc_pkg::cost_t     same_cost;
  scc_pkg::cost_t     right_cost;
  scc_pkg::cost_t     cost;
  scc_pkg::cost_sel_t sel;
  scc_pkg::lb_wr_t    wr;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign w        = scc_pkg::eff_width(width_r);

  // column of the item at the input
  always_comb begin
    col_s  = in_frame_start ? '0 : col_r;
    base_s = in_frame_start ? 1'b1 : base_r;
    c        = col_s;
    row_base = base_s;
    // width lowered below the current column: start a fresh non-base row
    if (scc_pkg::WIDTH_BITS'(col_s) >= w) begin
      c        = '0;
      row_base = 1'b0;
    end
    c_plus1 = scc_pkg::WIDTH_BITS'(c) + scc_pkg::WIDTH_BITS'(1);
    last    = (c_plus1 == w);
  end

  assign sel.base_row  = row_base;
  assign sel.use_left  = (c != '0);
  assign sel.use_right = (c_plus1 < w);

  scc_cost_unit u_cost (
    .energy     (in_energy),
    .same_cost  (same_cost),
    .left_cost  (left_r),
    .right_cost (right_cost),
    .sel        (sel),
    .cost       (cost)
  );

  always_comb begin
    col_nxt       = col_r;
    base_nxt      = base_r;
    left_nxt      = left_r;
    width_nxt     = cfg_wr_en ? cfg_wr_data : width_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      col_nxt       = last ? '0 : c_plus1[scc_pkg::COL_BITS-1:0];
      base_nxt      = last ? 1'b0 : row_base;
      left_nxt      = same_cost;
      out_valid_nxt = 1'b1;
    end
  end

  // read ahead for the next item, from the next column and width
  always_comb begin
    w_la = scc_pkg::eff_width(width_nxt);
    c_la = col_nxt;
    if (scc_pkg::WIDTH_BITS'(col_nxt) >= w_la) begin
      c_la = '0;
    end
    rd_a_addr = c_la;
    rd_b_addr = c_la + scc_pkg::COL_BITS'(1);
  end

  assign wr.en   = accept;
  assign wr.addr = c;
  assign wr.data = cost;

  scc_line_buf u_line_buf (
    .clk       (clk),
    .wr        (wr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (same_cost),
    .rd_b_data (right_cost)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      base_r      <= 1'b1;
      left_r      <= '0;
      width_r     <= scc_pkg::WIDTH_BITS'(scc_pkg::MAX_WIDTH);
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      left_r      <= left_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_cost_r    <= cost;
      out_row_end_r <= last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cost    = out_cost_r;
  assign out_row_end = out_row_end_r;

endmodule

`default_nettype wire

// ===== rtl/core/scc_line_buf.sv =====
// scc_line_buf: previous-row cost store, one write port and two registered read ports
// with forwarding of a write that lands on a read address in the same cycle; uses scc_pkg
`default_nettype none

module scc_line_buf (
  input  wire logic            clk,
  input  wire scc_pkg::lb_wr_t wr,
  input  wire scc_pkg::col_t   rd_a_addr,
  input  wire scc_pkg::col_t   rd_b_addr,
  output scc_pkg::cost_t       rd_a_data,
  output scc_pkg::cost_t       rd_b_data
);

  scc_pkg::cost_t mem [scc_pkg::MAX_WIDTH];

  scc_pkg::cost_t rd_a_r;
  scc_pkg::cost_t rd_b_r;
  scc_pkg::cost_t fwd_data_r;
  logic           fwd_a_r;
  logic           fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // the array read returns the old entry when written at the same edge
  always_ff @(posedge clk) begin
    fwd_a_r    <= wr.en && (wr.addr == rd_a_addr);
    fwd_b_r    <= wr.en && (wr.addr == rd_b_addr);
    fwd_data_r <= wr.data;
  end

  assign rd_a_data = fwd_a_r ? fwd_data_r : rd_a_r;
  assign rd_b_data = fwd_b_r ? fwd_data_r : rd_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/scc_cost_unit.sv =====
// scc_cost_unit: three-way minimum over the previous row plus energy, saturating, or energy alone
// on a base row; combinational; uses scc_pkg
`default_nettype none

module scc_cost_unit (
  input  wire scc_pkg::energy_t   energy,
  input  wire scc_pkg::cost_t     same_cost,
  input  wire scc_pkg::cost_t     left_cost,
  input  wire scc_pkg::cost_t     right_cost,
  input  wire scc_pkg::cost_sel_t sel,
  output scc_pkg::cost_t          cost
);

  scc_pkg::cost_t                 best_lr;
  scc_pkg::cost_t                 best;
  logic [scc_pkg::COST_BITS:0]    sum;

  always_comb begin
    best_lr = same_cost;
    if (sel.use_left && (left_cost < best_lr)) begin
      best_lr = left_cost;
    end
    best = best_lr;
    if (sel.use_right && (right_cost < best)) begin
      best = right_cost;
    end
    sum = {1'b0, best} + (scc_pkg::COST_BITS + 1)'(energy);
    if (sel.base_row) begin
      cost = scc_pkg::COST_BITS'(energy);
    end else if (sum[scc_pkg::COST_BITS]) begin
      cost = '1;
    end else begin
      cost = sum[scc_pkg::COST_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sim/seam_cumulative_cost_top_tb.sv =====
// seam_cumulative_cost_top_tb: self-checking bench for the streaming seam cost block
// depends on scc_pkg and seam_cumulative_cost_top; predicts each cost and row end per pixel
`timescale 1ns / 100ps

module seam_cumulative_cost_top_tb;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_AFTER = 1150;

  typedef struct {
    scc_pkg::energy_t energy;
    logic             frame_start;
  } pixel_t;

  typedef struct {
    scc_pkg::cost_t cost;
    logic           row_end;
  } cost_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  scc_pkg::energy_t in_energy = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  scc_pkg::cost_t   out_cost;
  logic             out_row_end;
  logic             cfg_wr_en = 1'b0;
  scc_pkg::width_t  cfg_wr_data = '0;

  seam_cumulative_cost_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_energy      (in_energy),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cost       (out_cost),
    .out_row_end    (out_row_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  pixel_t       pixel_q[$];
  cost_result_t cost_expected[$];
  int           sent_cnt = 0;
  int           acc_cnt = 0;
  int           err_cnt = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;

  // width register as last written
  scc_pkg::width_t width_reg = scc_pkg::width_t'(2048);

  // predicted block state
  bit [scc_pkg::COST_BITS-1:0] row_costs[scc_pkg::MAX_WIDTH];
  scc_pkg::cost_t              left_cost = '0;
  int                          next_col = 0;
  bit                          base_row = 1'b1;

  // stimulus-side tracking, used to keep reads on written line entries
  bit gen_written[scc_pkg::MAX_WIDTH];
  int gen_col = 0;
  bit gen_base = 1'b1;

  function automatic int active_cols(input scc_pkg::width_t w);
    int r;
    r = int'(w);
    if (r == 0) r = 1;
    if (r > scc_pkg::MAX_WIDTH) r = scc_pkg::MAX_WIDTH;
    return r;
  endfunction

  function automatic scc_pkg::energy_t rand_energy();
    scc_pkg::energy_t e;
    case ($urandom_range(0, 7))
      0: e = '0;
      1: e = '1;
      2: e = scc_pkg::energy_t'($urandom_range(0, 15));
      default: e = scc_pkg::energy_t'($urandom);
    endcase
    return e;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (err_cnt < 100) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // minimum seam cost for one accepted pixel
  task automatic predict_cost(input scc_pkg::energy_t e, input logic fs);
    int             w;
    int             c;
    scc_pkg::cost_t old;
    scc_pkg::cost_t best;
    logic [32:0]    sum;
    cost_result_t   r;
    w = active_cols(width_reg);
    if (fs) begin
      next_col = 0;
      base_row = 1'b1;
    end
    c = next_col;
    if (c >= w) begin
      c = 0;
      base_row = 1'b0;
    end
    old = row_costs[c];
    if (base_row) begin
      r.cost = scc_pkg::cost_t'(e);
    end else begin
      best = old;
      if (c > 0 && left_cost < best) best = left_cost;
      if (c + 1 < w && row_costs[c+1] < best) best = row_costs[c+1];
      sum = {17'b0, e} + {1'b0, best};
      r.cost = sum[32] ? '1 : sum[31:0];
    end
    left_cost = old;
    row_costs[c] = r.cost;
    r.row_end = (c + 1 == w);
    if (r.row_end) begin
      next_col = 0;
      base_row = 1'b0;
    end else begin
      next_col = c + 1;
    end
    cost_expected.insert(cost_expected.size(), r);
  endtask

  // a non-base pixel that would read a never-written entry becomes a frame start
  task automatic queue_pixel(input scc_pkg::energy_t e, input bit fs);
    int     w;
    int     c;
    bit     b;
    bit     f;
    pixel_t p;
    w = active_cols(width_reg);
    f = fs;
    c = f ? 0 : gen_col;
    b = f ? 1'b1 : gen_base;
    if (c >= w) begin
      c = 0;
      b = 1'b0;
    end
    if (!b && (!gen_written[c] || (c + 1 < w && !gen_written[c+1]))) begin
      f = 1'b1;
      c = 0;
      b = 1'b1;
    end
    gen_written[c] = 1'b1;
    if (c + 1 == w) begin
      gen_col = 0;
      gen_base = 1'b0;
    end else begin
      gen_col = c + 1;
      gen_base = b;
    end
    p.energy = e;
    p.frame_start = f;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || sent_cnt != acc_cnt || cost_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_width(input int v);
    wait_idle();
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= scc_pkg::width_t'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = scc_pkg::width_t'(v);
    @(posedge clk);
  endtask

  // input side: items presented at the falling edge
  always @(negedge clk) begin : drive_pixels
    pixel_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (sent_cnt == acc_cnt) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        p = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_energy <= p.energy;
        in_frame_start <= p.frame_start;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_cost(in_energy, in_frame_start);
      acc_cnt <= acc_cnt + 1;
    end
  end

  always @(posedge clk) begin : check_costs
    cost_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cost_expected.size() == 0) begin
        flag_mismatch($sformatf("cost %0d with no item waiting", out_cost));
      end else begin
        want = cost_expected.pop_front();
        if (out_cost !== want.cost)
          flag_mismatch($sformatf("cost %0d, want %0d", out_cost, want.cost));
        if (out_row_end !== want.row_end)
          flag_mismatch($sformatf("row_end %b, want %b", out_row_end, want.row_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("seam_cumulative_cost_top_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int rand_items;
    int n;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // base row at the reset width, with a restart mid-row
    queue_pixel(16'hFFFF, 1'b1);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'h0001, 1'b0);
    queue_pixel(16'h8000, 1'b0);
    queue_pixel(16'h7FFF, 1'b0);
    queue_pixel(16'h00FF, 1'b0);
    queue_pixel(16'hFF00, 1'b0);
    queue_pixel(16'h1234, 1'b1);
    repeat (5) queue_pixel(rand_energy(), 1'b0);

    // width zero acts as one; column past width wraps to a later row
    set_width(0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'h0003, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);

    set_width(5);
    repeat (3) queue_pixel(rand_energy(), 1'b0);
    set_width(2);
    repeat (4) queue_pixel(rand_energy(), 1'b0);
    set_width(3);
    repeat (2) queue_pixel(rand_energy(), 1'b0);
    queue_pixel(16'hFFFF, 1'b1);
    repeat (4) queue_pixel(rand_energy(), 1'b0);

    // widths above the line size act as the full line
    set_width(4095);
    queue_pixel(rand_energy(), 1'b1);
    repeat (40) queue_pixel(rand_energy(), 1'b0);
    set_width(2049);
    repeat (20) queue_pixel(rand_energy(), 1'b0);

    // held off until every result is back before new content
    wait_idle();

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: set_width($urandom_range(0, 4095));
        1, 2, 3, 4: set_width($urandom_range(1, 8));
        5, 6, 7: set_width($urandom_range(9, 40));
        default: set_width($urandom_range(41, 300));
      endcase
      if (rand_items >= CALM_AFTER) calm = 1'b1;
      n = $urandom_range(30, 120);
      if ($urandom_range(0, 3) == 0) queue_pixel(rand_energy(), 1'b1);
      repeat (n) queue_pixel(rand_energy(), $urandom_range(0, 79) == 0);
      rand_items += n;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (cost_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never came", cost_expected.size()));
    if (err_cnt == 0) begin
      $display("seam_cumulative_cost_top_tb: clean");
    end else begin
      $display("seam_cumulative_cost_top_tb: errors");
    end
    $finish;
  end

endmodule
